>>> src/terminal_key_sequence_decoder_assert.svh
// assertion helpers shared by the decoder modules
// each macro expects clk and arst_n in the scope where it is used
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define TKSD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TKSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/tksd_pkg.sv
package tksd_pkg;

	// default depth of the event-bundle queue
	localparam int QUEUE_DEPTH = 4;

	// most events a single byte can cause
	localparam int MAX_EVENTS = 3;

	// key codes
	localparam logic [3:0] KEY_NONE  = 4'd0;
	localparam logic [3:0] KEY_CHAR  = 4'd1;
	localparam logic [3:0] KEY_ENTER = 4'd2;
	localparam logic [3:0] KEY_BKSP  = 4'd3;
	localparam logic [3:0] KEY_TAB   = 4'd4;
	localparam logic [3:0] KEY_ESC   = 4'd5;
	localparam logic [3:0] KEY_UP    = 4'd6;
	localparam logic [3:0] KEY_DOWN  = 4'd7;
	localparam logic [3:0] KEY_RIGHT = 4'd8;
	localparam logic [3:0] KEY_LEFT  = 4'd9;
	localparam logic [3:0] KEY_HOME  = 4'd10;
	localparam logic [3:0] KEY_END   = 4'd11;
	localparam logic [3:0] KEY_DEL   = 4'd12;
	localparam logic [3:0] KEY_PGUP  = 4'd13;
	localparam logic [3:0] KEY_PGDN  = 4'd14;

	// input request: one raw terminal byte
	typedef struct packed {
		logic [7:0] in_byte;
		logic       chunk_end;
	} in_req_t;

	// output request: one key event
	typedef struct packed {
		logic [3:0] key_code;
		logic       ctrl_flag;
		logic       alt_flag;
		logic [7:0] char_value;
		logic       last_of_run;
	} out_req_t;

	// one decoded event inside a bundle
	typedef struct packed {
		logic [3:0] key;
		logic       ctrl;
		logic       alt;
		logic [7:0] chr;
	} event_t;

	// all events caused by one byte, slot 0 first
	typedef struct packed {
		logic [1:0]                 count;
		event_t [MAX_EVENTS-1:0]    evt;
	} bundle_t;

endpackage

>>> src/terminal_key_sequence_decoder.sv
// the first event of a byte is registered in the bundle queue, then in the output register
// bytes are taken one per cycle while the queue has room; events leave one per
// cycle while key_ready allows, and a byte with several events sends them in turn
// a bundle queue of QueueDepth entries absorbs bursts at chunk ends
// reset: arst_n clears the parser state, the queue level and the output valid flag
module terminal_key_sequence_decoder #(
	parameter int QueueDepth = tksd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  tksd_pkg::in_req_t  byte_data,
	output logic               key_valid,
	input  logic               key_ready,
	output tksd_pkg::out_req_t key_data
);

	logic              push_valid;
	logic              push_ready;
	tksd_pkg::bundle_t push_data;
	logic              head_valid;
	tksd_pkg::bundle_t head_data;
	logic              pop;

	// parser and classifier
	tksd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// bundle queue
	tksd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	// event serializer
	tksd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_data   (key_data)
	);

endmodule

>>> src/tksd_front.sv
`include "terminal_key_sequence_decoder_assert.svh"

module tksd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  tksd_pkg::in_req_t  byte_data,
	output logic               push_valid,
	output tksd_pkg::bundle_t  push_data,
	input  logic               push_ready
);

	// parser phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ESC     = 3'd1;
	localparam logic [2:0] PH_BRACKET = 3'd2;
	localparam logic [2:0] PH_ONE     = 3'd3;
	localparam logic [2:0] PH_SEMI    = 3'd4;
	localparam logic [2:0] PH_FINAL   = 3'd5;

	// bytes with a meaning to the parser
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_CTRL_Z = 8'h1a;
	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7f;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_FIVE   = 8'h35;
	localparam logic [7:0] CH_SIX    = 8'h36;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_TILDE  = 8'h7e;
	localparam logic [7:0] CH_UP     = 8'h41;
	localparam logic [7:0] CH_DOWN   = 8'h42;
	localparam logic [7:0] CH_RIGHT  = 8'h43;
	localparam logic [7:0] CH_LEFT   = 8'h44;
	localparam logic [7:0] CH_HOME   = 8'h48;
	localparam logic [7:0] CH_END    = 8'h46;
	localparam logic [7:0] CTRL_BASE = 8'h60;

	typedef struct packed {
		logic              emit;
		logic              to_esc;
		tksd_pkg::event_t  evt;
	} fresh_t;

	typedef struct packed {
		logic              tilde;
		tksd_pkg::event_t  evt;
	} final_t;

	function automatic tksd_pkg::event_t make_evt(input logic [3:0] key, input logic ctrl,
		input logic alt, input logic [7:0] chr);
		tksd_pkg::event_t e;
		e.key  = key;
		e.ctrl = ctrl;
		e.alt  = alt;
		e.chr  = chr;
		return e;
	endfunction

	// byte seen from the idle phase
	function automatic fresh_t fresh_decode(input logic [7:0] b, input logic last);
		fresh_t r;
		r = '0;
		priority if (b == CH_ESC) begin
			if (last) begin
				r.emit = 1'b1;
				r.evt  = make_evt(tksd_pkg::KEY_ESC, 1'b0, 1'b0, CH_NUL);
			end else begin
				r.to_esc = 1'b1;
			end
		end else if (b == CH_CR || b == CH_LF) begin
			r.emit = 1'b1;
			r.evt  = make_evt(tksd_pkg::KEY_ENTER, 1'b0, 1'b0, CH_NUL);
		end else if (b == CH_DEL || b == CH_BS) begin
			r.emit = 1'b1;
			r.evt  = make_evt(tksd_pkg::KEY_BKSP, 1'b0, 1'b0, CH_NUL);
		end else if (b == CH_TAB) begin
			r.emit = 1'b1;
			r.evt  = make_evt(tksd_pkg::KEY_TAB, 1'b0, 1'b0, CH_NUL);
		end else if (b != CH_NUL && b <= CH_CTRL_Z) begin
			// ctrl letter: 1 maps to 'a'
			r.emit = 1'b1;
			r.evt  = make_evt(tksd_pkg::KEY_CHAR, 1'b1, 1'b0, b + CTRL_BASE);
		end else if (b >= CH_SPACE && b < CH_DEL) begin
			r.emit = 1'b1;
			r.evt  = make_evt(tksd_pkg::KEY_CHAR, 1'b0, 1'b0, b);
		end else begin
			r.emit = 1'b0;
		end
		return r;
	endfunction

	// final byte of a cursor, delete or page sequence
	function automatic final_t final_decode(input logic [7:0] c, input logic ctrl);
		final_t r;
		r = '0;
		unique case (c)
			CH_UP:    r.evt = make_evt(tksd_pkg::KEY_UP, ctrl, 1'b0, CH_NUL);
			CH_DOWN:  r.evt = make_evt(tksd_pkg::KEY_DOWN, ctrl, 1'b0, CH_NUL);
			CH_RIGHT: r.evt = make_evt(tksd_pkg::KEY_RIGHT, ctrl, 1'b0, CH_NUL);
			CH_LEFT:  r.evt = make_evt(tksd_pkg::KEY_LEFT, ctrl, 1'b0, CH_NUL);
			CH_HOME:  r.evt = make_evt(tksd_pkg::KEY_HOME, 1'b0, 1'b0, CH_NUL);
			CH_END:   r.evt = make_evt(tksd_pkg::KEY_END, 1'b0, 1'b0, CH_NUL);
			CH_THREE: begin
				r.evt   = make_evt(tksd_pkg::KEY_DEL, 1'b0, 1'b0, CH_NUL);
				r.tilde = 1'b1;
			end
			CH_FIVE: begin
				r.evt   = make_evt(tksd_pkg::KEY_PGUP, 1'b0, 1'b0, CH_NUL);
				r.tilde = 1'b1;
			end
			CH_SIX: begin
				r.evt   = make_evt(tksd_pkg::KEY_PGDN, 1'b0, 1'b0, CH_NUL);
				r.tilde = 1'b1;
			end
			default:  r.evt = make_evt(tksd_pkg::KEY_ESC, 1'b0, 1'b0, CH_NUL);
		endcase
		return r;
	endfunction

	logic [2:0]        phase_q, phase_d;
	logic [7:0]        held_q, held_d;
	logic              skip_q, skip_d;
	logic              accept;
	logic [7:0]        b;
	logic              last;
	logic              mod_ctrl;
	logic              skip_hit;
	fresh_t            fr;
	final_t            fn;
	tksd_pkg::bundle_t bnd;

	assign byte_ready = push_ready;
	assign accept     = byte_valid && byte_ready;
	assign b          = byte_data.in_byte;
	assign last       = byte_data.chunk_end;
	assign mod_ctrl   = (held_q == CH_FIVE) || (held_q == CH_SIX);
	assign skip_hit   = skip_q && (phase_q == PH_IDLE) && (b == CH_TILDE);
	assign fr         = fresh_decode(b, last);
	assign fn         = final_decode(b, (phase_q == PH_FINAL) ? mod_ctrl : 1'b0);

	// classify the byte against the current phase
	always_comb begin
		bnd     = '0;
		phase_d = phase_q;
		held_d  = held_q;
		skip_d  = 1'b0;
		if (skip_hit) begin
			phase_d = phase_q;
		end else begin
			unique case (phase_q)
				PH_ESC: begin
					phase_d = PH_IDLE;
					if (b == CH_LBRACK) begin
						if (last) begin
							bnd.count  = 2'd1;
							bnd.evt[0] = make_evt(tksd_pkg::KEY_NONE, 1'b0, 1'b0, CH_NUL);
						end else begin
							phase_d = PH_BRACKET;
						end
					end else begin
						bnd.count  = 2'd1;
						bnd.evt[0] = make_evt(tksd_pkg::KEY_CHAR, 1'b0, 1'b1, b);
					end
				end
				PH_BRACKET: begin
					if (b == CH_ONE && !last) begin
						phase_d = PH_ONE;
					end else begin
						phase_d    = PH_IDLE;
						bnd.count  = 2'd1;
						bnd.evt[0] = fn.evt;
						skip_d     = fn.tilde && !last;
					end
				end
				PH_ONE: begin
					if (b == CH_SEMI && !last) begin
						phase_d = PH_SEMI;
					end else begin
						// held "1" turns into esc, byte replayed from idle
						phase_d    = fr.to_esc ? PH_ESC : PH_IDLE;
						bnd.count  = fr.emit ? 2'd2 : 2'd1;
						bnd.evt[0] = make_evt(tksd_pkg::KEY_ESC, 1'b0, 1'b0, CH_NUL);
						bnd.evt[1] = fr.evt;
					end
				end
				PH_SEMI: begin
					if (last) begin
						// chunk cut after "1;": esc, then ';' and the byte replayed
						phase_d    = PH_IDLE;
						bnd.count  = fr.emit ? 2'd3 : 2'd2;
						bnd.evt[0] = make_evt(tksd_pkg::KEY_ESC, 1'b0, 1'b0, CH_NUL);
						bnd.evt[1] = make_evt(tksd_pkg::KEY_CHAR, 1'b0, 1'b0, CH_SEMI);
						bnd.evt[2] = fr.evt;
					end else begin
						held_d  = b;
						phase_d = PH_FINAL;
					end
				end
				PH_FINAL: begin
					held_d     = '0;
					phase_d    = PH_IDLE;
					bnd.count  = 2'd1;
					bnd.evt[0] = fn.evt;
					skip_d     = fn.tilde && !last;
				end
				default: begin
					phase_d    = fr.to_esc ? PH_ESC : PH_IDLE;
					bnd.count  = fr.emit ? 2'd1 : 2'd0;
					bnd.evt[0] = fr.evt;
				end
			endcase
			// lookahead never crosses a chunk end
			if (last) begin
				phase_d = PH_IDLE;
				held_d  = '0;
				skip_d  = 1'b0;
			end
		end
	end

	assign push_valid = accept && (bnd.count != 2'd0);
	assign push_data  = bnd;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
			skip_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			skip_q  <= skip_d;
		end
	end

	`TKSD_ASSERT_IMPLIES(a_skip_only_idle, skip_q, phase_q == PH_IDLE,
		"tilde skip pending outside idle phase")
	`TKSD_ASSERT_IMPLIES(a_held_only_final, held_q != 8'h00, phase_q == PH_FINAL,
		"modifier held outside final phase")

endmodule

>>> src/tksd_queue.sv
`include "terminal_key_sequence_decoder_assert.svh"

module tksd_queue #(
	parameter int Depth = tksd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  tksd_pkg::bundle_t  push_data,
	output logic               push_ready,
	output logic               head_valid,
	output tksd_pkg::bundle_t  head_data,
	input  logic               pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	tksd_pkg::bundle_t mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign push_ready = (count_q != CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// bundle storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TKSD_ASSERT_ALWAYS(a_level_in_range, count_q <= CntW'(Depth),
		"queue level beyond depth")

endmodule

>>> src/tksd_back.sv
`include "terminal_key_sequence_decoder_assert.svh"

module tksd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  tksd_pkg::bundle_t  head_data,
	output logic               pop,
	output logic               key_valid,
	input  logic               key_ready,
	output tksd_pkg::out_req_t key_data
);

	logic [1:0]         idx_q;
	logic               out_valid_q;
	tksd_pkg::out_req_t out_q;
	logic               load;
	logic               take;
	logic               last_evt;
	tksd_pkg::event_t   evt;

	// output register free or being emptied this cycle
	assign load     = !out_valid_q || key_ready;
	assign take     = load && head_valid;
	assign evt      = head_data.evt[idx_q];
	assign last_evt = (idx_q == head_data.count - 2'd1);
	assign pop      = take && last_evt;

	// walk the bundle one event per cycle while the output register can load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= last_evt ? 2'd0 : idx_q + 2'd1;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (key_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// event payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.key_code    <= evt.key;
			out_q.ctrl_flag   <= evt.ctrl;
			out_q.alt_flag    <= evt.alt;
			out_q.char_value  <= evt.chr;
			out_q.last_of_run <= last_evt;
		end
	end

	assign key_valid = out_valid_q;
	assign key_data  = out_q;

	`TKSD_ASSERT_IMPLIES(a_idx_within_bundle, head_valid, idx_q < head_data.count,
		"event index past end of bundle")

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// byte values the decoder treats specially
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0a;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_ESC      = 8'h1b;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DEL      = 8'h7f;
	localparam logic [7:0] CH_TOP      = 8'hff;
	localparam logic [7:0] CH_LBRACKET = "[";
	localparam logic [7:0] CH_ONE      = "1";
	localparam logic [7:0] CH_SEMI     = ";";
	localparam logic [7:0] CH_TILDE    = "~";
	localparam logic [7:0] CH_LOWER_A  = "a";
	localparam logic [7:0] CTRL_LAST   = 8'd26;

	localparam logic [7:0] NAV_FINALS [6]  = '{"A", "B", "C", "D", "H", "F"};
	localparam logic [7:0] EDIT_FINALS [3] = '{"3", "5", "6"};

	// where the decoder is inside an escape sequence
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_ESC,
		SCAN_CSI,
		SCAN_CSI_ONE,
		SCAN_CSI_SEMI,
		SCAN_CSI_MOD
	} scan_phase_t;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		tksd_pkg::in_req_t req;
		int unsigned       gap;
		bit                drain;
	} pending_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	tksd_pkg::in_req_t  byte_data = '0;
	logic               key_valid;
	logic               key_ready = 1'b0;
	tksd_pkg::out_req_t key_data;

	// decoder state as the testbench sees it
	scan_phase_t scan_phase = SCAN_IDLE;
	logic [7:0]  csi_modifier = 8'h00;
	logic        tilde_armed = 1'b0;

	tksd_pkg::out_req_t key_burst[$];
	tksd_pkg::out_req_t expected_keys[$];
	pending_byte_t      pending_bytes[$];

	pending_byte_t      next_byte;
	bit                 staged;
	int unsigned        gap_left;
	int unsigned        gap_mode;
	bit                 drain_next;
	int unsigned        bytes_queued;
	int unsigned        bytes_sent;
	int unsigned        chunks_sent;
	int unsigned        keys_seen;
	int unsigned        stall_left;
	int unsigned        rx_mode;
	int unsigned        mismatches;
	logic [14:0]        codes_seen = '0;
	tksd_pkg::out_req_t want;

	terminal_key_sequence_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_data   (key_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] key event %0d: %s", $time, keys_seen, what);
	endtask

	// wait length per request: none, full range, or short
	function automatic int unsigned draw_wait(input int unsigned mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 19);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic void add_key(input logic [3:0] code, input logic ctrl,
			input logic alt, input logic [7:0] chr);
		tksd_pkg::out_req_t ev;
		ev.key_code    = code;
		ev.ctrl_flag   = ctrl;
		ev.alt_flag    = alt;
		ev.char_value  = chr;
		ev.last_of_run = 1'b0;
		if (key_burst.size() < tksd_pkg::MAX_EVENTS)
			key_burst.insert(key_burst.size(), ev);
	endfunction

	// one byte decoded as if nothing were pending
	function automatic void decode_plain(input logic [7:0] b, input logic last_byte);
		scan_phase = SCAN_IDLE;
		if (b == CH_ESC) begin
			if (last_byte)
				add_key(tksd_pkg::KEY_ESC, 1'b0, 1'b0, 8'h00);
			else
				scan_phase = SCAN_ESC;
		end else if (b == CH_CR || b == CH_LF) begin
			add_key(tksd_pkg::KEY_ENTER, 1'b0, 1'b0, 8'h00);
		end else if (b == CH_DEL || b == CH_BS) begin
			add_key(tksd_pkg::KEY_BKSP, 1'b0, 1'b0, 8'h00);
		end else if (b == CH_TAB) begin
			add_key(tksd_pkg::KEY_TAB, 1'b0, 1'b0, 8'h00);
		end else if (b != CH_NUL && b <= CTRL_LAST) begin
			add_key(tksd_pkg::KEY_CHAR, 1'b1, 1'b0, CH_LOWER_A + b - 8'd1);
		end else if (b >= CH_SPACE && b < CH_DEL) begin
			add_key(tksd_pkg::KEY_CHAR, 1'b0, 1'b0, b);
		end
	endfunction

	// closing byte of an ESC [ sequence
	function automatic void decode_csi_final(input logic [7:0] c, input logic ctrl,
			input logic last_byte);
		scan_phase = SCAN_IDLE;
		case (c)
			"A": add_key(tksd_pkg::KEY_UP, ctrl, 1'b0, 8'h00);
			"B": add_key(tksd_pkg::KEY_DOWN, ctrl, 1'b0, 8'h00);
			"C": add_key(tksd_pkg::KEY_RIGHT, ctrl, 1'b0, 8'h00);
			"D": add_key(tksd_pkg::KEY_LEFT, ctrl, 1'b0, 8'h00);
			"H": add_key(tksd_pkg::KEY_HOME, 1'b0, 1'b0, 8'h00);
			"F": add_key(tksd_pkg::KEY_END, 1'b0, 1'b0, 8'h00);
			"3": begin
				add_key(tksd_pkg::KEY_DEL, 1'b0, 1'b0, 8'h00);
				tilde_armed = !last_byte;
			end
			"5": begin
				add_key(tksd_pkg::KEY_PGUP, 1'b0, 1'b0, 8'h00);
				tilde_armed = !last_byte;
			end
			"6": begin
				add_key(tksd_pkg::KEY_PGDN, 1'b0, 1'b0, 8'h00);
				tilde_armed = !last_byte;
			end
			default: add_key(tksd_pkg::KEY_ESC, 1'b0, 1'b0, 8'h00);
		endcase
	endfunction

	// works out the key events one accepted byte causes
	function automatic void predict_keys(input tksd_pkg::in_req_t req);
		logic [7:0] b;
		logic       at_end;
		logic       mod_ctrl;
		b = req.in_byte;
		at_end = req.chunk_end;
		key_burst.delete();

		// a tilde right after delete or page keys is swallowed
		if (tilde_armed) begin
			tilde_armed = 1'b0;
			if (scan_phase == SCAN_IDLE && b == CH_TILDE)
				return;
		end

		case (scan_phase)
			SCAN_ESC: begin
				scan_phase = SCAN_IDLE;
				if (b == CH_LBRACKET) begin
					if (at_end)
						add_key(tksd_pkg::KEY_NONE, 1'b0, 1'b0, 8'h00);
					else
						scan_phase = SCAN_CSI;
				end else begin
					add_key(tksd_pkg::KEY_CHAR, 1'b0, 1'b1, b);
				end
			end
			SCAN_CSI: begin
				if (b == CH_ONE && !at_end)
					scan_phase = SCAN_CSI_ONE;
				else
					decode_csi_final(b, 1'b0, at_end);
			end
			SCAN_CSI_ONE: begin
				if (b == CH_SEMI && !at_end) begin
					scan_phase = SCAN_CSI_SEMI;
				end else begin
					add_key(tksd_pkg::KEY_ESC, 1'b0, 1'b0, 8'h00);
					decode_plain(b, at_end);
				end
			end
			SCAN_CSI_SEMI: begin
				// a chunk cut after "1;" replays the held bytes
				if (at_end) begin
					add_key(tksd_pkg::KEY_ESC, 1'b0, 1'b0, 8'h00);
					decode_plain(CH_SEMI, 1'b0);
					decode_plain(b, 1'b1);
				end else begin
					csi_modifier = b;
					scan_phase = SCAN_CSI_MOD;
				end
			end
			SCAN_CSI_MOD: begin
				mod_ctrl = (csi_modifier == "5" || csi_modifier == "6");
				csi_modifier = 8'h00;
				decode_csi_final(b, mod_ctrl, at_end);
			end
			default: decode_plain(b, at_end);
		endcase

		if (at_end) begin
			scan_phase = SCAN_IDLE;
			csi_modifier = 8'h00;
			tilde_armed = 1'b0;
		end
		if (key_burst.size() != 0)
			key_burst[key_burst.size() - 1].last_of_run = 1'b1;
		foreach (key_burst[i])
			expected_keys.insert(expected_keys.size(), key_burst[i]);
	endfunction

	// queues a run of bytes, chunk end on the last one if asked
	task automatic queue_chunk(input byte_q_t bytes, input bit end_last);
		pending_byte_t p;
		foreach (bytes[i]) begin
			if (bytes_queued % 20 == 0)
				gap_mode = $urandom_range(0, 2);
			p.req.in_byte = bytes[i];
			p.req.chunk_end = end_last && (i == bytes.size() - 1);
			p.gap = draw_wait(gap_mode);
			p.drain = drain_next;
			drain_next = 1'b0;
			pending_bytes.insert(pending_bytes.size(), p);
			bytes_queued++;
		end
	endtask

	// byte driver: predicts on each accepted request, then presents the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
			staged = 1'b0;
			gap_left = 0;
		end else begin
			if (byte_valid && byte_ready) begin
				predict_keys(byte_data);
				bytes_sent++;
				if (byte_data.chunk_end)
					chunks_sent++;
			end
			if (!byte_valid || byte_ready) begin
				if (!staged && pending_bytes.size() != 0) begin
					next_byte = pending_bytes.pop_front();
					gap_left = next_byte.gap;
					staged = 1'b1;
				end
				if (staged && gap_left == 0 &&
						!(next_byte.drain && expected_keys.size() != 0)) begin
					byte_data <= next_byte.req;
					byte_valid <= 1'b1;
					staged = 1'b0;
				end else begin
					byte_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// key monitor: checks each accepted event and stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ready <= 1'b0;
			stall_left = 0;
			rx_mode = 0;
		end else begin
			if (key_valid && key_ready) begin
				keys_seen++;
				if (key_data.key_code <= tksd_pkg::KEY_PGDN)
					codes_seen[key_data.key_code] = 1'b1;
				if (expected_keys.size() == 0) begin
					report_mismatch($sformatf("unexpected event %p", key_data));
				end else begin
					want = expected_keys.pop_front();
					if (key_data.key_code !== want.key_code)
						report_mismatch($sformatf("key_code %0d, expected %0d",
							key_data.key_code, want.key_code));
					if (key_data.ctrl_flag !== want.ctrl_flag)
						report_mismatch($sformatf("ctrl_flag %b, expected %b",
							key_data.ctrl_flag, want.ctrl_flag));
					if (key_data.alt_flag !== want.alt_flag)
						report_mismatch($sformatf("alt_flag %b, expected %b",
							key_data.alt_flag, want.alt_flag));
					if (key_data.char_value !== want.char_value)
						report_mismatch($sformatf("char_value %h, expected %h",
							key_data.char_value, want.char_value));
					if (key_data.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							key_data.last_of_run, want.last_of_run));
				end
				if (keys_seen % 20 == 0)
					rx_mode = $urandom_range(0, 2);
				stall_left = draw_wait(rx_mode);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			key_ready <= (stall_left == 0);
		end
	end

	// stimulus and end of run
	initial begin
		byte_q_t     seq;
		bit          end_last;
		int unsigned cut;
		int unsigned seq_count;
		int unsigned noise_len;

		// directed: field extremes and the odd corners of the parser
		queue_chunk('{CH_NUL}, 1'b0);
		queue_chunk('{CTRL_LAST}, 1'b0);
		queue_chunk('{CH_ESC}, 1'b1);
		queue_chunk('{CH_ESC, CH_TOP}, 1'b1);
		queue_chunk('{CH_ESC, CH_LBRACKET}, 1'b1);
		queue_chunk('{CH_ESC, CH_LBRACKET, CH_ONE, CH_SEMI, "5", "H"}, 1'b0);
		queue_chunk('{CH_ESC, CH_LBRACKET, "3", CH_TILDE}, 1'b0);
		queue_chunk('{CH_ESC, CH_LBRACKET, CH_ONE, "x"}, 1'b0);
		queue_chunk('{CH_ESC, CH_LBRACKET, CH_ONE, CH_SEMI, "q"}, 1'b1);
		queue_chunk('{CH_ESC, CH_LBRACKET, "Z"}, 1'b1);

		// random: mostly whole key sequences, some cut short, some noise
		seq_count = 0;
		while (bytes_queued < 160) begin
			seq.delete();
			end_last = ($urandom_range(0, 1) == 1);
			if (seq_count % 25 == 0)
				drain_next = 1'b1;
			case ($urandom_range(0, 9))
				0: seq.insert(seq.size(), 8'($urandom_range(32, 126)));
				1: seq.insert(seq.size(), 8'($urandom_range(0, 31)));
				2: seq = '{CH_ESC, 8'($urandom)};
				3, 4, 5: begin
					seq = '{CH_ESC, CH_LBRACKET};
					if ($urandom_range(0, 1) == 1) begin
						seq.insert(seq.size(), CH_ONE);
						seq.insert(seq.size(), CH_SEMI);
						case ($urandom_range(0, 3))
							0: seq.insert(seq.size(), "5");
							1: seq.insert(seq.size(), "6");
							default: seq.insert(seq.size(), 8'($urandom_range(32, 126)));
						endcase
					end
					seq.insert(seq.size(), NAV_FINALS[$urandom_range(0, 5)]);
				end
				6: begin
					seq = '{CH_ESC, CH_LBRACKET, EDIT_FINALS[$urandom_range(0, 2)]};
					if ($urandom_range(0, 3) != 0)
						seq.insert(seq.size(), CH_TILDE);
				end
				7: begin
					seq = '{CH_ESC, CH_LBRACKET};
					case ($urandom_range(0, 2))
						0: ;
						1: seq.insert(seq.size(), CH_ONE);
						default: begin
							seq.insert(seq.size(), CH_ONE);
							seq.insert(seq.size(), CH_SEMI);
							seq.insert(seq.size(), 8'($urandom));
						end
					endcase
					seq.insert(seq.size(), 8'($urandom));
				end
				default: begin
					noise_len = $urandom_range(1, 4);
					repeat (noise_len)
						seq.insert(seq.size(), 8'($urandom));
				end
			endcase
			// cut some sequences short at a chunk end
			if (seq.size() > 1 && $urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, seq.size() - 1);
				while (seq.size() > cut)
					void'(seq.pop_back());
				end_last = 1'b1;
			end
			queue_chunk(seq, end_last);
			seq_count++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || staged || byte_valid)
			@(posedge clk);
		for (int n = 0; n < 4000 && expected_keys.size() != 0; n++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (expected_keys.size() != 0)
			report_mismatch($sformatf("%0d expected events never arrived",
				expected_keys.size()));

		$display("sent %0d bytes in %0d chunks, checked %0d key events",
			bytes_sent, chunks_sent, keys_seen);
		$display("key codes seen, one bit per code: %015b", codes_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout waiting for the decoder");
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/tksd_pkg.sv
src/tksd_front.sv
src/tksd_queue.sv
src/tksd_back.sv
src/terminal_key_sequence_decoder.sv
sim/testbench.sv
